@@ sv/vpg_pkg.sv @@
// shared types, codes and reset values of the vectorscope persistence grid
`timescale 1ns / 1ps
package vpg_pkg;

  localparam int GRID_SIZE_DEF = 64;

  typedef enum logic [2:0] {
    CMD_PLOT  = 3'd0,
    CMD_FRAME = 3'd1,
    CMD_FADE  = 3'd2,
    CMD_READ  = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_e;

  localparam logic [1:0] REG_HIT   = 2'd0;
  localparam logic [1:0] REG_FRAME = 2'd1;
  localparam logic [1:0] REG_FADE  = 2'd2;
  localparam logic [1:0] REG_CLAMP = 2'd3;

  localparam logic [15:0] HIT_RST   = 16'd5243;
  localparam logic [15:0] FRAME_RST = 16'd62915;
  localparam logic [15:0] FADE_RST  = 16'd55706;
  localparam logic [15:0] CLAMP_RST = 16'd63570;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [5:0]         read_row;
    logic [5:0]         read_col;
  } vpg_in_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [5:0]  plot_col;
    logic [5:0]  upper_row;
    logic [5:0]  lower_row;
  } vpg_out_t;

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

@@ sv/vectorscope_persistence_grid.sv @@
// top level: command sequencer around the cell memory
//
// channel | signals                          | transaction when
// in      | in_valid_i, in_ready_o, in_data_i   | valid and ready high
// out     | out_valid_o, out_ready_i, out_data_o| valid and ready high
// cfg     | cfg_we_i, cfg_idx_i, cfg_data_i     | write enable high
//
// one item at a time; a clamped plot runs 17 root steps and two 34 step divisions,
// then two read-modify-writes on the one memory port; other plots skip the root and
// division steps
// frame/fade decay and clear sweep every cell
// after reset a clearing pass over every cell runs before input is taken
// a finished result waits in the output register while the next item is accepted
`timescale 1ns / 1ps
module vectorscope_persistence_grid #(
  parameter int GRID_SIZE = vpg_pkg::GRID_SIZE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  vpg_pkg::vpg_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output vpg_pkg::vpg_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i
);
  import vpg_pkg::*;

  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(CELLS);
  localparam int IDXW  = $clog2(GRID_SIZE);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_POINT = 11'b00000000100,
    S_RU    = 11'b00000001000,
    S_WU    = 11'b00000010000,
    S_RL    = 11'b00000100000,
    S_WL    = 11'b00001000000,
    S_READ  = 11'b00010000000,
    S_RDW   = 11'b00100000000,
    S_DECAY = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_e;

  state_e          state_q;
  logic [15:0]     hit_q, frame_q, fade_q, clamp_q, factor_q;
  logic [AW:0]     cnt_q;
  logic            pv_q, emit_q, out_valid_q;
  logic [AW-1:0]   pa_q, rd_addr_q;
  logic [15:0]     cell_q, upv_q;
  logic [IDXW-1:0] col_q, up_q, lo_q;
  vpg_out_t        out_q;

  logic            accept, pt_done, sweep_end;
  logic [IDXW-1:0] pt_col, pt_up, pt_lo;
  logic [AW-1:0]   addr_u, addr_l, raddr, waddr, rd_addr;
  logic            we;
  logic [15:0]     wdata, rdata, newv;
  logic [31:0]     dprod;

  assign accept    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign sweep_end = (cnt_q == (AW + 1)'(CELLS));
  assign addr_u    = AW'(int'(up_q) * GRID_SIZE + int'(col_q));
  assign addr_l    = AW'(int'(lo_q) * GRID_SIZE + int'(col_q));
  assign rd_addr   = AW'(int'(in_data_i.read_row) * GRID_SIZE + int'(in_data_i.read_col));
  assign newv      = sat_add(rdata, hit_q);
  assign dprod     = 32'(rdata) * 32'(factor_q);

  vpg_point #(.GRID_SIZE(GRID_SIZE)) u_point (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && in_data_i.command == CMD_PLOT),
    .left_i  (in_data_i.left_sample),
    .right_i (in_data_i.right_sample),
    .clamp_i (clamp_q),
    .done_o  (pt_done),
    .col_o   (pt_col),
    .up_o    (pt_up),
    .lo_o    (pt_lo)
  );

  vpg_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    we    = 1'b0;
    waddr = addr_u;
    wdata = newv;
    raddr = cnt_q[AW-1:0];
    unique case (state_q)
      S_CLEAR: begin
        we    = !sweep_end;
        waddr = cnt_q[AW-1:0];
        wdata = 16'd0;
      end
      S_RU:   raddr = addr_u;
      S_WU:   we = 1'b1;
      S_RL:   raddr = addr_l;
      S_WL: begin
        we    = 1'b1;
        waddr = addr_l;
      end
      S_READ: raddr = rd_addr_q;
      S_DECAY: begin
        we    = pv_q;
        waddr = pa_q;
        wdata = dprod[31:16];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      emit_q      <= 1'b0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      hit_q       <= HIT_RST;
      frame_q     <= FRAME_RST;
      fade_q      <= FADE_RST;
      clamp_q     <= CLAMP_RST;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_HIT:   hit_q <= cfg_data_i;
          REG_FRAME: frame_q <= cfg_data_i;
          REG_FADE:  fade_q <= cfg_data_i;
          REG_CLAMP: clamp_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (sweep_end) begin
            state_q <= emit_q ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cell_q <= 16'd0;
            col_q  <= '0;
            up_q   <= '0;
            lo_q   <= '0;
            cnt_q  <= '0;
            pv_q   <= 1'b0;
            unique case (in_data_i.command)
              CMD_PLOT: state_q <= S_POINT;
              CMD_FRAME: begin
                factor_q <= frame_q;
                state_q  <= S_DECAY;
              end
              CMD_FADE: begin
                factor_q <= fade_q;
                state_q  <= S_DECAY;
              end
              CMD_READ: begin
                rd_addr_q <= rd_addr;
                if (9'(in_data_i.read_row) < 9'(GRID_SIZE)
                    && 9'(in_data_i.read_col) < 9'(GRID_SIZE)) begin
                  state_q <= S_READ;
                end else begin
                  state_q <= S_DONE;
                end
              end
              CMD_CLEAR: begin
                emit_q  <= 1'b1;
                state_q <= S_CLEAR;
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_POINT: begin
          if (pt_done) begin
            col_q   <= pt_col;
            up_q    <= pt_up;
            lo_q    <= pt_lo;
            state_q <= S_RU;
          end
        end
        S_RU: state_q <= S_WU;
        S_WU: begin
          upv_q   <= newv;
          state_q <= S_RL;
        end
        S_RL: state_q <= S_WL;
        S_WL: begin
          cell_q  <= (addr_u == addr_l) ? newv : upv_q;
          state_q <= S_DONE;
        end
        S_READ: state_q <= S_RDW;
        S_RDW: begin
          cell_q  <= rdata;
          state_q <= S_DONE;
        end
        S_DECAY: begin
          pv_q <= !sweep_end;
          pa_q <= cnt_q[AW-1:0];
          if (!sweep_end) begin
            cnt_q <= cnt_q + 1'b1;
          end else if (!pv_q) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q      <= 1'b1;
            out_q.cell_value <= cell_q;
            out_q.plot_col   <= 6'(col_q);
            out_q.upper_row  <= 6'(up_q);
            out_q.lower_row  <= 6'(lo_q);
            emit_q           <= 1'b0;
            state_q          <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("item accepted while busy");
  a_point_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_done |-> state_q == S_POINT)
    else $error("point unit finished outside plot");
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !we)
    else $error("memory written while idle");
  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && !out_valid_q |=> out_valid_q)
    else $error("result lost");
`endif
endmodule

@@ sv/vpg_ram.sv @@
// generic single write port memory with registered read
`timescale 1ns / 1ps
module vpg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

@@ sv/vpg_point.sv @@
// point unit: squares, clamp test, iterative root and divide, grid indices
`timescale 1ns / 1ps
module vpg_point #(
  parameter int GRID_SIZE = vpg_pkg::GRID_SIZE_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [15:0]           left_i,
  input  logic signed [15:0]           right_i,
  input  logic [15:0]                  clamp_i,
  output logic                         done_o,
  output logic [$clog2(GRID_SIZE)-1:0] col_o,
  output logic [$clog2(GRID_SIZE)-1:0] up_o,
  output logic [$clog2(GRID_SIZE)-1:0] lo_o
);
  localparam int IDXW = $clog2(GRID_SIZE);

  typedef enum logic [5:0] {
    P_IDLE = 6'b000001,
    P_SQ   = 6'b000010,
    P_ROOT = 6'b000100,
    P_DMUL = 6'b001000,
    P_DIV  = 6'b010000,
    P_IDX  = 6'b100000
  } pstate_e;

  pstate_e     state_q;
  logic        neg_q, which_q, done_q;
  logic [16:0] smag_q, mag_q, root_q, quo_q;
  logic [15:0] clamp_q;
  logic [33:0] acc_q, c2_q, x_q, num_q;
  logic [1:0]  step_q;
  logic [19:0] rem_q;
  logic [17:0] drem_q;
  logic [5:0]  cnt_q;
  logic [IDXW-1:0] col_q, up_q, lo_q;

  logic signed [16:0] side, sum;
  logic [16:0] mul_a, mul_b;
  logic [33:0] prod;
  logic [19:0] rem_n, trial;
  logic [18:0] dr_n;
  logic        qbit;
  logic [17:0] dr_next;
  logic [16:0] quo_n;

  function automatic logic [IDXW-1:0] gidx(input logic [17:0] t);
    logic [17+IDXW:0] p;
    logic [IDXW:0]    g;
    p = (18 + IDXW)'(t) * (18 + IDXW)'(GRID_SIZE - 1);
    g = p[17+IDXW:17];
    return (g > (IDXW + 1)'(GRID_SIZE - 1)) ? IDXW'(GRID_SIZE - 1) : g[IDXW-1:0];
  endfunction

  assign side = 17'(right_i) - 17'(left_i);
  assign sum  = 17'(right_i) + 17'(left_i);

  always_comb begin
    mul_a = smag_q;
    mul_b = smag_q;
    if (state_q == P_DMUL) begin
      mul_a = which_q ? mag_q : smag_q;
      mul_b = {1'b0, clamp_q};
    end else if (step_q == 2'd1) begin
      mul_a = mag_q;
      mul_b = mag_q;
    end else if (step_q == 2'd2) begin
      mul_a = {1'b0, clamp_q};
      mul_b = {1'b0, clamp_q};
    end
  end

  assign prod    = 34'(mul_a) * 34'(mul_b);
  assign rem_n   = {rem_q[17:0], x_q[33:32]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign dr_n    = {drem_q, num_q[33]};
  assign qbit    = dr_n >= {2'b00, root_q};
  assign dr_next = qbit ? 18'(dr_n - {2'b00, root_q}) : dr_n[17:0];
  assign quo_n   = {quo_q[15:0], qbit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_IDLE;
      done_q  <= 1'b0;
      step_q  <= 2'd0;
      cnt_q   <= 6'd0;
      which_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        P_IDLE: begin
          if (start_i) begin
            neg_q   <= side[16];
            smag_q  <= side[16] ? 17'(-side) : 17'(side);
            mag_q   <= sum[16] ? 17'(-sum) : 17'(sum);
            clamp_q <= clamp_i;
            step_q  <= 2'd0;
            state_q <= P_SQ;
          end
        end
        P_SQ: begin
          step_q <= step_q + 2'd1;
          unique case (step_q)
            2'd0: acc_q <= prod;
            2'd1: acc_q <= acc_q + prod;
            2'd2: c2_q <= prod;
            default: begin
              if (acc_q > c2_q) begin
                x_q     <= acc_q;
                root_q  <= 17'd0;
                rem_q   <= 20'd0;
                cnt_q   <= 6'd0;
                state_q <= P_ROOT;
              end else begin
                state_q <= P_IDX;
              end
            end
          endcase
        end
        P_ROOT: begin
          if (rem_n >= trial) begin
            rem_q  <= rem_n - trial;
            root_q <= {root_q[15:0], 1'b1};
          end else begin
            rem_q  <= rem_n;
            root_q <= {root_q[15:0], 1'b0};
          end
          x_q   <= {x_q[31:0], 2'b00};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd16) begin
            which_q <= 1'b0;
            state_q <= P_DMUL;
          end
        end
        P_DMUL: begin
          num_q   <= prod;
          drem_q  <= 18'd0;
          quo_q   <= 17'd0;
          cnt_q   <= 6'd0;
          state_q <= P_DIV;
        end
        P_DIV: begin
          drem_q <= dr_next;
          quo_q  <= quo_n;
          num_q  <= {num_q[32:0], 1'b0};
          cnt_q  <= cnt_q + 6'd1;
          if (cnt_q == 6'd33) begin
            if (which_q) begin
              mag_q   <= quo_n;
              state_q <= P_IDX;
            end else begin
              smag_q  <= quo_n;
              which_q <= 1'b1;
              state_q <= P_DMUL;
            end
          end
        end
        P_IDX: begin
          col_q   <= gidx(neg_q ? 18'd65536 - 18'(smag_q) : 18'd65536 + 18'(smag_q));
          up_q    <= gidx(18'd65536 - 18'(mag_q));
          lo_q    <= gidx(18'd65536 + 18'(mag_q));
          done_q  <= 1'b1;
          state_q <= P_IDLE;
        end
        default: state_q <= P_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign col_o  = col_q;
  assign up_o   = up_q;
  assign lo_o   = lo_q;
endmodule
